/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the filter chain RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/lfof_pkg.sv */
// Types, widths, codes and table builders for the LFO filter chain.
// No dependencies.
`default_nettype none
package lfof_pkg;

  localparam int LP_W      = 24;  // lowpass / highpass state, Q3.20
  localparam int SMP_W     = 16;
  localparam int PH_W      = 24;
  localparam int LFO_W     = 17;  // LFO value, -32768..32768
  localparam int CUT_W     = 32;  // cutoff in Q.15 Hz
  localparam int W_W       = 36;  // w in Q.16, also divisor width
  localparam int ALPHA_W   = 24;
  localparam int NUM_W     = 60;  // dividend w*2^24 + den/2
  localparam int DIFF_W    = 26;
  localparam int MUL_AW    = 34;
  localparam int MUL_BW    = 32;
  localparam int MUL_PW    = 66;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 23;

  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam longint      TWO_PI_Q30 = 64'sd6746518852;
  localparam longint      Q30_ONE    = 64'sd1073741824;
  localparam longint      Q30_HALF   = 64'sd536870912;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_CUTOFF = 3'd0,
    REG_RESONANCE   = 3'd1,
    REG_HP_COEFF    = 3'd2,
    REG_LFO_SHAPE   = 3'd3,
    REG_LFO_STEP    = 3'd4,
    REG_LFO_DEPTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAW      = 2'd3
  } lfo_shape_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LFO_GO, S_LFO_WAIT, S_W_GO, S_W_WAIT, S_DEN, S_DIV_GO, S_DIV_WAIT,
    S_FB_GO, S_FB_WAIT, S_S1_GO, S_S1_WAIT, S_D2, S_S2_GO, S_S2_WAIT,
    S_HP_PREP, S_HP_GO, S_HP_WAIT, S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + Q30_HALF) >>> 30;
  endfunction

  // Sine entry: small-angle series, then eight angle doublings.
  function automatic logic signed [15:0] sine_entry(input int Idx, input int Size);
    longint Span, a, a2, a3, a4, a5, s, c, ns, r;
    int k;
    Span = longint'(Size) <<< 8;
    a  = (TWO_PI_Q30 * longint'(Idx) + (longint'(Size) <<< 7)) / Span;
    a2 = qmul(a, a);
    a3 = qmul(a2, a);
    a5 = qmul(a3, a2);
    a4 = qmul(a2, a2);
    s  = a - a3 / 6 + a5 / 120;
    c  = Q30_ONE - a2 / 2 + a4 / 24;
    for (k = 0; k < 8; k++) begin
      ns = 2 * qmul(s, c);
      c  = Q30_ONE - 2 * qmul(s, s);
      s  = ns;
    end
    r = (s + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    return 16'(r);
  endfunction

  // Tanh entry at 4*i/N: series at 1/64 of the argument, six doublings.
  function automatic logic [14:0] tanh_entry(input int Idx, input int Size);
    longint Den, a, a2, a3, a5, t, r;
    int k;
    a  = ((longint'(Idx) <<< 26) + longint'(Size / 2)) / Size;
    a2 = qmul(a, a);
    a3 = qmul(a2, a);
    a5 = qmul(a3, a2);
    t  = a - a3 / 3 + (2 * a5) / 15;
    for (k = 0; k < 6; k++) begin
      Den = Q30_ONE + qmul(t, t);
      t   = ((2 * t) * Q30_ONE + Den / 2) / Den;
    end
    r = (t + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < 64'sd0) r = 64'sd0;
    return 15'(r);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/lfo_modulated_resonant_filter_chain_core.sv */
// LFO-modulated resonant lowpass followed by a one-pole highpass.
// Depends on lfof_pkg, lfof_lfo, lfof_tanh, lfof_smul, lfof_sdiv, assert_macros.svh.
//
// Use:
//   Input channel in_valid/in_ready carries one Q1.15 word, sample_in. Output
//   channel out_valid/out_ready returns one filtered Q1.15 word per input word,
//   in order. Configuration is a plain write port (cfg_write, cfg_index,
//   cfg_data); write only while the block is idle. Unknown indexes are dropped.
// Sequence:
//   One word is in flight at a time: the next word is accepted once the
//   result of the last one is in the output register. Each word takes six
//   passes of the shared bit-serial multiplier (LFO depth, 2*pi scaling,
//   resonance feedback, two lowpass stages, highpass) plus a restoring
//   divide for alpha, with single-step states between them.
// Stall:
//   The result sits in an output register; the next input word is accepted
//   while it waits. If the receiver still holds the earlier word when the next
//   result is ready, the sequencer holds until the slot frees.
// Reset:
//   Synchronous, active high. Filter state and LFO phase clear to zero, the
//   registers take their reset values, and the block comes up ready.
`default_nettype none
`include "assert_macros.svh"
module lfo_modulated_resonant_filter_chain_core #(
  parameter int SAMPLE_RATE_HZ  = 48000,
  parameter int TANH_TABLE_SIZE = 256,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lfof_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lfof_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lfof_pkg::SMP_W-1:0]     sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lfof_pkg::SMP_W-1:0]     sample_out
);
  localparam int LW = lfof_pkg::LP_W;
  localparam int DW = lfof_pkg::DIFF_W;
  // cutoff upper clamp fs/2 in Q.15 Hz, and fs in Q.16 for the divisor
  localparam logic [lfof_pkg::CUT_W-1:0] Cut_Max =
    lfof_pkg::CUT_W'(longint'(SAMPLE_RATE_HZ) * 64'sd16384);
  localparam logic [lfof_pkg::W_W-1:0]   Den_Base =
    lfof_pkg::W_W'(longint'(SAMPLE_RATE_HZ) * 64'sd65536);

  // configuration registers
  logic [14:0] base_cutoff_hz;
  logic [15:0] resonance_gain;
  logic [15:0] highpass_coeff;
  logic [1:0]  lfo_shape;
  logic [22:0] lfo_phase_step;
  logic [14:0] lfo_depth_hz;

  // filter state
  logic signed [LW-1:0]  lowpass_first;
  logic signed [LW-1:0]  lowpass_second;
  logic signed [15:0]    highpass_last_in;
  logic signed [LW-1:0]  highpass_last_out;

  // working registers
  lfof_pkg::state_t                   state, state_next;
  logic signed [15:0]                 x_hold;
  logic [lfof_pkg::CUT_W-1:0]         cutoff;
  logic [lfof_pkg::W_W-1:0]           w;
  logic [lfof_pkg::W_W-1:0]           den;
  logic signed [DW-1:0]               diff;
  logic signed [15:0]                 hin_hold;

  // unit connections
  logic                               mul_start;
  logic signed [lfof_pkg::MUL_AW-1:0] mul_a;
  logic [lfof_pkg::MUL_BW-1:0]        mul_b;
  lfof_pkg::unit_stat_t               mul_stat;
  logic signed [lfof_pkg::MUL_PW-1:0] mul_prod;
  logic                               div_start;
  logic [lfof_pkg::NUM_W-1:0]         div_num;
  lfof_pkg::unit_stat_t               div_stat;
  logic [lfof_pkg::ALPHA_W-1:0]       alpha;
  logic                               phase_adv;
  logic signed [lfof_pkg::LFO_W-1:0]  lfo_val;
  logic signed [15:0]                 tanh_val;
  logic                               in_fire;
  logic                               out_load;
  logic                               mul_waiting;

  // datapath terms
  logic signed [33:0] cut_raw;
  logic [62:0]        w_sum;
  logic signed [32:0] fb_sum;
  logic signed [23:0] fb;
  logic signed [50:0] st_sum;
  logic signed [26:0] st_delta;
  logic signed [LW-1:0] st_base;
  logic signed [LW-1:0] st_new;
  logic signed [24:0] s2_round;
  logic signed [15:0] hin;
  logic signed [42:0] hp_round;
  logic signed [24:0] ho_round;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) r = 24'sd8388607;
    else if (v < -28'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sd32767;
    else if (v < -20'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  lfof_lfo #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_lfo (
    .clk     (clk),
    .rst     (rst),
    .shape   (lfo_shape),
    .step    (lfo_phase_step),
    .advance (phase_adv),
    .value   (lfo_val)
  );

  lfof_tanh #(.TANH_TABLE_SIZE(TANH_TABLE_SIZE)) u_tanh (
    .x (lowpass_second),
    .t (tanh_val)
  );

  lfof_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  lfof_sdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .stat  (div_stat),
    .q     (alpha)
  );

  assign in_ready = (state == lfof_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == lfof_pkg::S_FIN) && (!out_valid || out_ready);

  // states that wait on the shared multiplier
  assign mul_waiting = (state == lfof_pkg::S_LFO_WAIT) || (state == lfof_pkg::S_W_WAIT) ||
                       (state == lfof_pkg::S_FB_WAIT)  || (state == lfof_pkg::S_S1_WAIT) ||
                       (state == lfof_pkg::S_S2_WAIT)  || (state == lfof_pkg::S_HP_WAIT);

  // dividend: w*2^24 plus half the divisor, for round-to-nearest alpha
  assign div_num = {w, 24'd0} + lfof_pkg::NUM_W'(den >> 1);

  // cutoff = base*2^15 + lfo*depth
  assign cut_raw = $signed({4'd0, base_cutoff_hz, 15'd0}) + $signed(mul_prod[33:0]);
  assign w_sum   = mul_prod[62:0] + 63'(64'd1 << 26);

  // resonance feedback, rounded by 2^9
  assign fb_sum = $signed(mul_prod[32:0]) + 33'sd256;
  assign fb     = fb_sum[32:9];

  // lowpass stage step, rounded by 2^24; base selects the stage being updated
  assign st_base  = (state == lfof_pkg::S_S1_WAIT) ? lowpass_first : lowpass_second;
  assign st_sum   = $signed(mul_prod[50:0]) + 51'sd8388608;
  assign st_delta = st_sum[50:24];
  assign st_new   = sat24(28'(st_base) + 28'(st_delta));

  // highpass input: second stage to Q1.15
  assign s2_round = 25'(lowpass_second) + 25'sd16;
  assign hin      = sat16(s2_round[24:5]);

  assign hp_round = $signed(mul_prod[42:0]) + 43'sd32768;
  assign ho_round = 25'(highpass_last_out) + 25'sd16;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_cutoff_hz <= 15'd1000;
      resonance_gain <= '0;
      highpass_coeff <= 16'hFFFF;
      lfo_shape      <= '0;
      lfo_phase_step <= '0;
      lfo_depth_hz   <= '0;
    end else if (cfg_write) begin
      unique case (lfof_pkg::cfg_reg_t'(cfg_index))
        lfof_pkg::REG_BASE_CUTOFF: base_cutoff_hz <= cfg_data[14:0];
        lfof_pkg::REG_RESONANCE:   resonance_gain <= cfg_data[15:0];
        lfof_pkg::REG_HP_COEFF:    highpass_coeff <= cfg_data[15:0];
        lfof_pkg::REG_LFO_SHAPE:   lfo_shape      <= cfg_data[1:0];
        lfof_pkg::REG_LFO_STEP:    lfo_phase_step <= cfg_data;
        lfof_pkg::REG_LFO_DEPTH:   lfo_depth_hz   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfof_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and unit requests
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    phase_adv  = 1'b0;
    unique case (state)
      lfof_pkg::S_IDLE:     if (in_valid) state_next = lfof_pkg::S_LFO_GO;
      lfof_pkg::S_LFO_GO: begin
        mul_start  = 1'b1;
        mul_a      = lfof_pkg::MUL_AW'(lfo_val);
        mul_b      = lfof_pkg::MUL_BW'(lfo_depth_hz);
        phase_adv  = (lfo_depth_hz != '0);
        state_next = lfof_pkg::S_LFO_WAIT;
      end
      lfof_pkg::S_LFO_WAIT: if (mul_stat.done) state_next = lfof_pkg::S_W_GO;
      lfof_pkg::S_W_GO: begin
        mul_start  = 1'b1;
        mul_a      = $signed({2'b00, cutoff});
        mul_b      = lfof_pkg::MUL_BW'(lfof_pkg::TWO_PI_Q28);
        state_next = lfof_pkg::S_W_WAIT;
      end
      lfof_pkg::S_W_WAIT:   if (mul_stat.done) state_next = lfof_pkg::S_DEN;
      lfof_pkg::S_DEN:      state_next = lfof_pkg::S_DIV_GO;
      lfof_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = lfof_pkg::S_DIV_WAIT;
      end
      lfof_pkg::S_DIV_WAIT: if (div_stat.done) state_next = lfof_pkg::S_FB_GO;
      lfof_pkg::S_FB_GO: begin
        mul_start  = 1'b1;
        mul_a      = lfof_pkg::MUL_AW'(tanh_val);
        mul_b      = lfof_pkg::MUL_BW'(resonance_gain);
        state_next = lfof_pkg::S_FB_WAIT;
      end
      lfof_pkg::S_FB_WAIT:  if (mul_stat.done) state_next = lfof_pkg::S_S1_GO;
      lfof_pkg::S_S1_GO: begin
        mul_start  = 1'b1;
        mul_a      = lfof_pkg::MUL_AW'(diff);
        mul_b      = lfof_pkg::MUL_BW'(alpha);
        state_next = lfof_pkg::S_S1_WAIT;
      end
      lfof_pkg::S_S1_WAIT:  if (mul_stat.done) state_next = lfof_pkg::S_D2;
      lfof_pkg::S_D2:       state_next = lfof_pkg::S_S2_GO;
      lfof_pkg::S_S2_GO: begin
        mul_start  = 1'b1;
        mul_a      = lfof_pkg::MUL_AW'(diff);
        mul_b      = lfof_pkg::MUL_BW'(alpha);
        state_next = lfof_pkg::S_S2_WAIT;
      end
      lfof_pkg::S_S2_WAIT:  if (mul_stat.done) state_next = lfof_pkg::S_HP_PREP;
      lfof_pkg::S_HP_PREP:  state_next = lfof_pkg::S_HP_GO;
      lfof_pkg::S_HP_GO: begin
        mul_start  = 1'b1;
        mul_a      = lfof_pkg::MUL_AW'(diff);
        mul_b      = lfof_pkg::MUL_BW'(highpass_coeff);
        state_next = lfof_pkg::S_HP_WAIT;
      end
      lfof_pkg::S_HP_WAIT:  if (mul_stat.done) state_next = lfof_pkg::S_FIN;
      lfof_pkg::S_FIN:      if (!out_valid || out_ready) state_next = lfof_pkg::S_IDLE;
      default:              state_next = lfof_pkg::S_IDLE;
    endcase
  end

  // working values: the input word at acceptance, the rest as each unit finishes or in a prep state
  always_ff @(posedge clk) begin
    if (in_fire) x_hold <= sample_in;
    if (state == lfof_pkg::S_LFO_WAIT && mul_stat.done) begin
      // clamp the cutoff to 1 Hz .. fs/2
      if (cut_raw < 34'sd32768) cutoff <= lfof_pkg::CUT_W'(32768);
      else if (cut_raw > $signed({2'b00, Cut_Max})) cutoff <= Cut_Max;
      else cutoff <= cut_raw[lfof_pkg::CUT_W-1:0];
    end
    if (state == lfof_pkg::S_W_WAIT && mul_stat.done) w <= w_sum[62:27];
    if (state == lfof_pkg::S_DEN) den <= Den_Base + w;
    if (state == lfof_pkg::S_FB_WAIT && mul_stat.done) begin
      // target minus first stage: x*32 - feedback - s1
      diff <= $signed({{5{x_hold[15]}}, x_hold, 5'd0}) - DW'(fb) - DW'(lowpass_first);
    end
    if (state == lfof_pkg::S_D2) diff <= DW'(lowpass_first) - DW'(lowpass_second);
    if (state == lfof_pkg::S_HP_PREP) begin
      hin_hold <= hin;
      diff     <= DW'(highpass_last_out) + DW'($signed({hin, 5'd0}))
                - DW'($signed({highpass_last_in, 5'd0}));
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass_first     <= '0;
      lowpass_second    <= '0;
      highpass_last_in  <= '0;
      highpass_last_out <= '0;
    end else begin
      if (state == lfof_pkg::S_S1_WAIT && mul_stat.done) lowpass_first <= st_new;
      if (state == lfof_pkg::S_S2_WAIT && mul_stat.done) lowpass_second <= st_new;
      if (state == lfof_pkg::S_HP_WAIT && mul_stat.done) begin
        highpass_last_in  <= hin_hold;
        highpass_last_out <= sat24(28'($signed(hp_round[42:16])));
      end
    end
  end

  // output register: load the finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) sample_out <= sat16(ho_round[24:5]);
  end

  `ASSERT_IMPLIES(a_mul_done_waiting, clk, rst, mul_stat.done, mul_waiting, "multiplier done early")
  `ASSERT_NEXT(a_accept_starts_lfo, clk, rst, in_fire, state == lfof_pkg::S_LFO_GO, "no LFO step")
endmodule
`default_nettype wire

/* hw/rtl/lfof_smul.sv */
// Bit-serial multiplier: signed multiplicand by unsigned multiplier, one bit a cycle.
// Depends on lfof_pkg.
`default_nettype none
module lfof_smul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lfof_pkg::MUL_AW-1:0]  a,
  input  logic        [lfof_pkg::MUL_BW-1:0]  b,
  output lfof_pkg::unit_stat_t                stat,
  output logic signed [lfof_pkg::MUL_PW-1:0]  prod
);
  localparam int CW = $clog2(lfof_pkg::MUL_BW);

  logic                               busy;
  logic                               done;
  logic [CW-1:0]                      cnt;
  logic signed [lfof_pkg::MUL_AW-1:0] areg;
  logic        [lfof_pkg::MUL_BW-1:0] breg;
  logic signed [lfof_pkg::MUL_AW-1:0] hi;
  logic        [lfof_pkg::MUL_BW-1:0] lo;
  logic signed [lfof_pkg::MUL_AW:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {hi[lfof_pkg::MUL_AW-1], hi}
             + (breg[0] ? {areg[lfof_pkg::MUL_AW-1], areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(lfof_pkg::MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      hi   <= '0;
    end else if (busy) begin
      hi   <= sum[lfof_pkg::MUL_AW:1];
      lo   <= {sum[0], lo[lfof_pkg::MUL_BW-1:1]};
      breg <= breg >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = {hi, lo};
endmodule
`default_nettype wire

/* hw/rtl/lfof_sdiv.sv */
// Restoring divider, one quotient bit a cycle, for the alpha coefficient.
// Depends on lfof_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lfof_sdiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lfof_pkg::NUM_W-1:0]          num,
  input  logic [lfof_pkg::W_W-1:0]            den,
  output lfof_pkg::unit_stat_t                stat,
  output logic [lfof_pkg::ALPHA_W-1:0]        q
);
  localparam int QW = lfof_pkg::ALPHA_W;
  localparam int RW = lfof_pkg::W_W;
  localparam int CW = $clog2(QW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dreg;
  logic [QW-1:0] nlo;
  logic [RW:0]   trial;
  logic          ge;

  assign trial = {rem, nlo[QW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[lfof_pkg::NUM_W-1:QW];
      nlo  <= num[QW-1:0];
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? RW'(trial - {1'b0, dreg}) : trial[RW-1:0];
      nlo <= nlo << 1;
      q   <= {q[QW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // the partial remainder never reaches the divisor, or the quotient overflows
  `ASSERT_IMPLIES(a_rem_below_den, clk, rst, busy, rem < dreg, "divider remainder overflow")
endmodule
`default_nettype wire

/* hw/rtl/lfof_lfo.sv */
// LFO: phase accumulator, waveform decode and sine table.
// Depends on lfof_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lfof_lfo #(
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [1:0]                         shape,
  input  logic [lfof_pkg::PH_W-2:0]          step,
  input  logic                               advance,
  output logic signed [lfof_pkg::LFO_W-1:0]  value
);
  localparam int SW = $clog2(SINE_TABLE_SIZE);
  localparam int PW = lfof_pkg::PH_W;

  logic [PW-1:0]       phase;
  logic signed [15:0]  sine_rom [SINE_TABLE_SIZE];
  logic [PW+12:0]      ph_scaled;
  logic [SW-1:0]       sidx;
  logic [PW-1:0]       tri_dist;
  logic signed [17:0]  tri_val;

  for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_sine
    assign sine_rom[g] = lfof_pkg::sine_entry(g, SINE_TABLE_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase + {1'b0, step};
    end
  end

  assign ph_scaled = (PW+13)'(phase) * (PW+13)'(SINE_TABLE_SIZE);
  assign sidx      = ph_scaled[PW +: SW];
  assign tri_dist  = phase[PW-1] ? {1'b0, phase[PW-2:0]}
                                 : PW'({1'b1, {(PW-1){1'b0}}} - {1'b0, phase});
  assign tri_val   = $signed({1'b0, tri_dist[PW-1:7]}) - 18'sd32768;

  always_comb begin
    unique case (lfof_pkg::lfo_shape_t'(shape))
      lfof_pkg::SHAPE_SINE:     value = 17'(sine_rom[sidx]);
      lfof_pkg::SHAPE_SQUARE:   value = phase[PW-1] ? -17'sd32768 : 17'sd32768;
      lfof_pkg::SHAPE_TRIANGLE: value = tri_val[16:0];
      lfof_pkg::SHAPE_SAW:      value = $signed({1'b0, phase[PW-1:8]}) - 17'sd32768;
      default:                  value = '0;
    endcase
  end

  // hold the phase unless the sequencer advances it
  `ASSERT_NEXT(a_phase_hold, clk, rst, !advance, $stable(phase), "LFO phase moved")
endmodule
`default_nettype wire

/* hw/rtl/lfof_tanh.sv */
// Table tanh of a Q3.20 value, sign restored, Q0.15 result.
// Depends on lfof_pkg.
`default_nettype none
module lfof_tanh #(
  parameter int TANH_TABLE_SIZE = 256
) (
  input  logic signed [lfof_pkg::LP_W-1:0] x,
  output logic signed [15:0]               t
);
  localparam int TW = $clog2(TANH_TABLE_SIZE);
  localparam int XW = lfof_pkg::LP_W;

  logic [14:0]    tanh_rom [TANH_TABLE_SIZE];
  logic [XW-1:0]  mag;
  logic [XW+12:0] scaled;
  logic [14:0]    idx_full;
  logic [TW-1:0]  idx;
  logic [14:0]    tv;

  for (genvar g = 0; g < TANH_TABLE_SIZE; g++) begin : g_tanh
    assign tanh_rom[g] = lfof_pkg::tanh_entry(g, TANH_TABLE_SIZE);
  end

  assign mag      = x[XW-1] ? (~x + 1'b1) : x;
  assign scaled   = (XW+13)'(mag) * (XW+13)'(TANH_TABLE_SIZE);
  assign idx_full = scaled[XW+12:22];
  // clamp beyond the table end
  assign idx      = (idx_full > 15'(TANH_TABLE_SIZE - 1)) ? TW'(TANH_TABLE_SIZE - 1)
                                                          : idx_full[TW-1:0];
  assign tv       = tanh_rom[idx];
  assign t        = x[XW-1] ? -$signed({1'b0, tv}) : $signed({1'b0, tv});
endmodule
`default_nettype wire
